FILE: design/scp_pkg.sv
// ----------------------------------------------------------------------------
// scp_pkg: shared definitions for the scanline cache slot policy core
// Field widths, register map and sequencer state encoding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package scp_pkg;

  // Fixed field widths
  localparam int ROW_W      = 12;
  localparam int SLOT_OUT_W = 6;
  localparam int HEIGHT_W   = 13;
  localparam int AGE_W      = 32;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  // Register map: index taken from paddr[2]
  localparam logic REG_IMAGE_HEIGHT = 1'b0;

  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd4096;

  // Sequencer states, one-hot
  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_LOOKUP = 7'b0000100,
    ST_SCAN   = 7'b0001000,
    ST_UPDATE = 7'b0010000,
    ST_MAPWR  = 7'b0100000,
    ST_RESP   = 7'b1000000
  } state_e;

endpackage

`default_nettype wire

FILE: design/scanline_cache_slot_policy_core.sv
// ----------------------------------------------------------------------------
// scanline_cache_slot_policy_core: row cache directory, FIFO replacement
// Maps image rows to cache slots; on a miss evicts the oldest-stamped slot.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the row map and slot
// memories and takes no request until it ends; image_height writes are
// taken at any time. Requests are handled one at a time: an out-of-range
// request goes straight to the response state, a hit first reads the row
// map, and a miss also runs the oldest-stamp search, which reads one slot
// stamp per cycle from the slot memory, then restamps the victim and writes
// the row map. A finished result sits in the output register while the next
// request is accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scanline_cache_slot_policy_core #(
  parameter int SLOTS    = 64,
  parameter int MAX_ROWS = 4096
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // request channel
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [scp_pkg::ROW_W-1:0]       row_i,
  // result channel
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic      [scp_pkg::SLOT_OUT_W-1:0]  slot_o,
  output logic                                 hit_o,
  output logic                                 evict_valid_o,
  output logic      [scp_pkg::ROW_W-1:0]       evicted_row_o,
  output logic                                 out_of_range_o,
  // configuration port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [scp_pkg::PADDR_W-1:0]     paddr,
  input  wire logic [scp_pkg::PDATA_W-1:0]     pwdata,
  output logic      [scp_pkg::PDATA_W-1:0]     prdata,
  output logic                                 pready
);

  localparam int RW    = scp_pkg::ROW_W;
  localparam int GW    = scp_pkg::AGE_W;
  localparam int HW    = scp_pkg::HEIGHT_W;
  localparam int SOW   = scp_pkg::SLOT_OUT_W;
  localparam int DW    = scp_pkg::PDATA_W;
  localparam int SW    = $clog2(SLOTS);
  localparam int AW    = $clog2(MAX_ROWS);
  localparam int MEW   = SW + 1;            // map entry: valid, slot
  localparam int SEW   = 1 + RW + GW;       // slot entry: valid, row, stamp
  localparam int CLR_N = (MAX_ROWS > SLOTS) ? MAX_ROWS : SLOTS;
  localparam int CW    = $clog2(CLR_N);

  scp_pkg::state_e state_q, state_d;

  logic [CW-1:0] clr_q, clr_d;
  logic [HW-1:0] height_q, height_d;
  logic [GW-1:0] load_cnt_q, load_cnt_d;
  logic          out_valid_q, out_valid_d;

  // per-request working registers
  logic [RW-1:0] row_q, row_d;
  logic          oor_q, oor_d;
  logic          hit_q, hit_d;
  logic [SW-1:0] slot_idx_q, slot_idx_d;
  logic [SW-1:0] scan_idx_q, scan_idx_d;
  logic [GW-1:0] best_age_q, best_age_d;
  logic          best_valid_q, best_valid_d;
  logic [RW-1:0] best_row_q, best_row_d;

  // output payload registers
  logic [SOW-1:0] out_slot_q, out_slot_d;
  logic           out_hit_q, out_hit_d;
  logic           out_ev_q, out_ev_d;
  logic [RW-1:0]  out_evrow_q, out_evrow_d;
  logic           out_oor_q, out_oor_d;

  // memory ports
  logic           map_we, map_re;
  logic [AW-1:0]  map_waddr;
  logic [MEW-1:0] map_wdata, map_rdata;
  logic           slot_we, slot_re;
  logic [SW-1:0]  slot_waddr, slot_raddr;
  logic [SEW-1:0] slot_wdata, slot_rdata;

  logic in_acc, oor_in, cfg_wr;
  logic [GW-1:0] scan_age;
  logic [RW-1:0] scan_row;
  logic          scan_valid;

  assign in_ready_o = (state_q == scp_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign oor_in     = ({1'b0, row_i} >= height_q) || (32'(row_i) >= 32'(MAX_ROWS));

  assign scan_age   = slot_rdata[GW-1:0];
  assign scan_row   = slot_rdata[GW +: RW];
  assign scan_valid = slot_rdata[SEW-1];

  // Row map: row -> {valid, slot}
  scp_ram #(
    .WIDTH (MEW),
    .DEPTH (MAX_ROWS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (map_re),
    .raddr_i (AW'(row_i)),
    .rdata_o (map_rdata)
  );

  // Slot table: slot -> {valid, row, load stamp}
  scp_ram #(
    .WIDTH (SEW),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .re_i    (slot_re),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == scp_pkg::REG_IMAGE_HEIGHT) ? DW'(height_q) : '0;

  always_comb begin
    height_d = height_q;
    if (cfg_wr && (paddr[2] == scp_pkg::REG_IMAGE_HEIGHT)) begin
      height_d = pwdata[HW-1:0];
    end
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    load_cnt_d   = load_cnt_q;
    row_d        = row_q;
    oor_d        = oor_q;
    hit_d        = hit_q;
    slot_idx_d   = slot_idx_q;
    scan_idx_d   = scan_idx_q;
    best_age_d   = best_age_q;
    best_valid_d = best_valid_q;
    best_row_d   = best_row_q;
    out_slot_d   = out_slot_q;
    out_hit_d    = out_hit_q;
    out_ev_d     = out_ev_q;
    out_evrow_d  = out_evrow_q;
    out_oor_d    = out_oor_q;
    out_valid_d  = out_valid_q && !out_ready_i;

    map_we     = 1'b0;
    map_re     = 1'b0;
    map_waddr  = AW'(row_q);
    map_wdata  = '0;
    slot_we    = 1'b0;
    slot_re    = 1'b0;
    slot_waddr = slot_idx_q;
    slot_wdata = '0;
    slot_raddr = '0;

    case (state_q)
      // clear both memories, one entry per cycle
      scp_pkg::ST_CLEAR: begin
        map_we     = (32'(clr_q) < 32'(MAX_ROWS));
        map_waddr  = AW'(clr_q);
        slot_we    = (32'(clr_q) < 32'(SLOTS));
        slot_waddr = SW'(clr_q);
        clr_d      = clr_q + 1'b1;
        if (clr_q == CW'(CLR_N - 1)) begin
          state_d = scp_pkg::ST_IDLE;
        end
      end
      // take a request and start the map read
      scp_pkg::ST_IDLE: begin
        if (in_acc) begin
          row_d        = row_i;
          oor_d        = oor_in;
          hit_d        = 1'b0;
          best_valid_d = 1'b0;
          slot_idx_d   = '0;
          if (oor_in) begin
            state_d = scp_pkg::ST_RESP;
          end else begin
            map_re  = 1'b1;
            state_d = scp_pkg::ST_LOOKUP;
          end
        end
      end
      // map data back: hit answers, miss starts the stamp scan
      scp_pkg::ST_LOOKUP: begin
        if (map_rdata[SW]) begin
          hit_d      = 1'b1;
          slot_idx_d = map_rdata[SW-1:0];
          state_d    = scp_pkg::ST_RESP;
        end else begin
          slot_re    = 1'b1;
          slot_raddr = '0;
          scan_idx_d = '0;
          state_d    = scp_pkg::ST_SCAN;
        end
      end
      // one stamp per cycle; strict less-than keeps the lowest index on ties
      scp_pkg::ST_SCAN: begin
        if ((scan_idx_q == '0) || (scan_age < best_age_q)) begin
          slot_idx_d   = scan_idx_q;
          best_age_d   = scan_age;
          best_valid_d = scan_valid;
          best_row_d   = scan_row;
        end
        if (scan_idx_q == SW'(SLOTS - 1)) begin
          state_d = scp_pkg::ST_UPDATE;
        end else begin
          slot_re    = 1'b1;
          slot_raddr = scan_idx_q + 1'b1;
          scan_idx_d = scan_idx_q + 1'b1;
        end
      end
      // restamp the victim, unmap its old row
      scp_pkg::ST_UPDATE: begin
        load_cnt_d = load_cnt_q + 1'b1;
        slot_we    = 1'b1;
        slot_waddr = slot_idx_q;
        slot_wdata = {1'b1, row_q, load_cnt_q + 1'b1};
        if (best_valid_q) begin
          map_we    = 1'b1;
          map_waddr = AW'(best_row_q);
          map_wdata = '0;
        end
        state_d = scp_pkg::ST_MAPWR;
      end
      // map the new row to the victim slot
      scp_pkg::ST_MAPWR: begin
        map_we    = 1'b1;
        map_waddr = AW'(row_q);
        map_wdata = {1'b1, slot_idx_q};
        state_d   = scp_pkg::ST_RESP;
      end
      // hand the result to the output register once it is free
      scp_pkg::ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_slot_d  = SOW'(slot_idx_q);
          out_hit_d   = hit_q;
          out_ev_d    = best_valid_q;
          out_evrow_d = best_valid_q ? best_row_q : '0;
          out_oor_d   = oor_q;
          state_d     = scp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = scp_pkg::ST_CLEAR;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= scp_pkg::ST_CLEAR;
      clr_q       <= '0;
      height_q    <= scp_pkg::HEIGHT_RST;
      load_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      height_q    <= height_d;
      load_cnt_q  <= load_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    row_q        <= row_d;
    oor_q        <= oor_d;
    hit_q        <= hit_d;
    slot_idx_q   <= slot_idx_d;
    scan_idx_q   <= scan_idx_d;
    best_age_q   <= best_age_d;
    best_valid_q <= best_valid_d;
    best_row_q   <= best_row_d;
    out_slot_q   <= out_slot_d;
    out_hit_q    <= out_hit_d;
    out_ev_q     <= out_ev_d;
    out_evrow_q  <= out_evrow_d;
    out_oor_q    <= out_oor_d;
  end

  assign out_valid_o    = out_valid_q;
  assign slot_o         = out_slot_q;
  assign hit_o          = out_hit_q;
  assign evict_valid_o  = out_ev_q;
  assign evicted_row_o  = out_evrow_q;
  assign out_of_range_o = out_oor_q;

`ifndef ASSERT_OFF
  // a hit never evicts and is never out of range
  a_hit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && hit_o) |-> (!evict_valid_o && !out_of_range_o))
    else $error("hit result carries eviction or range flag");

  // rejected requests report a blank result
  a_oor_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_of_range_o) |-> (slot_o == '0 && !hit_o && !evict_valid_o))
    else $error("out-of-range result not blank");

  // evicted row is zero unless an eviction happened
  a_evrow_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !evict_valid_o) |-> (evicted_row_o == '0))
    else $error("evicted row set without eviction");

  // the load counter moves only when a victim is restamped
  a_cnt_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_cnt_q != $past(load_cnt_q)) |-> ($past(state_q) == scp_pkg::ST_UPDATE))
    else $error("load counter changed outside update");
`endif

endmodule

`default_nettype wire

FILE: design/scp_ram.sv
// ----------------------------------------------------------------------------
// scp_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire
